[sv/scs_pkg.sv]
// ----------------------------------------------------------------------------
// Stratified class split package
// Shared types, command codes and widths for the split unit.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int CMD_W      = 2;
    localparam int LABEL_W    = 8;
    localparam int OUT_IDX_W  = 10;
    localparam int RATE_W     = 17;
    localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;       // hold the label of the accepted transaction
        logic clear_start;   // begin the clearing sweep of the class tables
        logic clear_step;    // clear one class entry
        logic load_rd;       // read the histogram entry of the held label
        logic load;          // store the label and count it
        logic prep_start;    // reset the class and sample cursors
        logic prep_class;    // read the histogram count of one class
        logic prep_class_wr; // write back take count and slot start
        logic prep_rd;       // read one stored label
        logic prep_slot_rd;  // read that label's slot
        logic prep_wr;       // write the ordered index and bump the slot
        logic emit_rd;       // read the ordered index at the cursor
        logic emit_lbl;      // read the label of that source
        logic emit_cnt;      // read the take count of that label
        logic emit_fin;      // form the result, update counts
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic class_done;
        logic sample_done;
        logic empty;
        logic full;
        logic label_ok;
        logic emit_end;
    } dp_stat_t;

endpackage

[sv/scs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/scs_datapath.sv]
// ----------------------------------------------------------------------------
// Stratified class split datapath
// Label store, class tables, ordered index and the position counters.
// ----------------------------------------------------------------------------
module scs_datapath import scs_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int CLASS_COUNT = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    input  logic [LABEL_W-1:0]   in_label,
    input  logic [RATE_W-1:0]    rate,
    output dp_stat_t             stat,
    output logic [OUT_IDX_W-1:0] res_source_index,
    output logic [LABEL_W-1:0]   res_class_label,
    output logic                 res_to_taken,
    output logic [OUT_IDX_W-1:0] res_dest_position,
    output logic                 res_last
);

    localparam int SA_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CA_W  = $clog2(CLASS_COUNT);
    localparam int CC_W  = $clog2(CLASS_COUNT + 1);
    localparam int PROD_W = CNT_W + RATE_W;

    // Counters and cursors.
    logic [CNT_W-1:0]     sample_count_reg, sample_count_next;
    logic [CNT_W-1:0]     cursor_reg, cursor_next;
    logic [CC_W-1:0]      class_reg, class_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [OUT_IDX_W-1:0] taken_pos_reg, taken_pos_next;
    logic [OUT_IDX_W-1:0] rem_pos_reg, rem_pos_next;
    logic [CNT_W-1:0]     take_prod_hi_reg;
    logic [LABEL_W-1:0]   lbl_reg;
    logic [LABEL_W-1:0]   load_label_reg;
    logic [SA_W-1:0]      src_reg;

    // Memories.
    logic              lbl_we;
    logic [SA_W-1:0]   lbl_addr;
    logic [LABEL_W-1:0] lbl_rdata;
    logic              hist_we;
    logic [CA_W-1:0]   hist_addr;
    logic [CNT_W-1:0]  hist_wdata, hist_rdata;
    logic              take_we;
    logic [CA_W-1:0]   take_addr;
    logic [CNT_W-1:0]  take_wdata, take_rdata;
    logic              slot_we;
    logic [CA_W-1:0]   slot_addr;
    logic [CNT_W-1:0]  slot_wdata, slot_rdata;
    logic              ord_we;
    logic [SA_W-1:0]   ord_addr;
    logic [SA_W-1:0]   ord_wdata, ord_rdata;

    logic [RATE_W-1:0]  rate_sat;
    logic [PROD_W-1:0]  prod;
    logic               taken;

    scs_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_SAMPLES)) u_label_ram (
        .aclk(aclk), .we(lbl_we), .addr(lbl_addr), .wdata(load_label_reg), .rdata(lbl_rdata)
    );
    scs_ram #(.WIDTH(CNT_W), .DEPTH(CLASS_COUNT)) u_hist_ram (
        .aclk(aclk), .we(hist_we), .addr(hist_addr), .wdata(hist_wdata), .rdata(hist_rdata)
    );
    scs_ram #(.WIDTH(CNT_W), .DEPTH(CLASS_COUNT)) u_take_ram (
        .aclk(aclk), .we(take_we), .addr(take_addr), .wdata(take_wdata), .rdata(take_rdata)
    );
    scs_ram #(.WIDTH(CNT_W), .DEPTH(CLASS_COUNT)) u_slot_ram (
        .aclk(aclk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
    );
    scs_ram #(.WIDTH(SA_W), .DEPTH(MAX_SAMPLES)) u_order_ram (
        .aclk(aclk), .we(ord_we), .addr(ord_addr), .wdata(ord_wdata), .rdata(ord_rdata)
    );

    assign rate_sat = (rate > RATE_ONE) ? RATE_ONE : rate;
    // Take count is the ceiling of count * rate / 65536.
    assign prod = PROD_W'(hist_rdata) * PROD_W'(rate_sat) + PROD_W'(17'd65535);
    assign taken = (take_rdata != '0);

    // Memory addressing and writes.
    always_comb begin
        lbl_we    = cmd.load;
        lbl_addr  = cmd.load ? sample_count_reg[SA_W-1:0] : cursor_reg[SA_W-1:0];
        if (cmd.emit_lbl) begin
            lbl_addr = ord_rdata;
        end
        hist_we    = 1'b0;
        hist_addr  = class_reg[CA_W-1:0];
        hist_wdata = hist_rdata + CNT_W'(1);
        take_we    = 1'b0;
        take_addr  = class_reg[CA_W-1:0];
        take_wdata = take_prod_hi_reg;
        slot_we    = 1'b0;
        slot_addr  = class_reg[CA_W-1:0];
        slot_wdata = run_reg;
        ord_we     = cmd.prep_wr;
        ord_addr   = cmd.prep_wr ? slot_rdata[SA_W-1:0] : cursor_reg[SA_W-1:0];
        ord_wdata  = cursor_reg[SA_W-1:0];
        if (cmd.clear_step) begin
            hist_we    = 1'b1;
            hist_wdata = '0;
            take_we    = 1'b1;
            take_wdata = '0;
        end
        // The histogram entry is read in one cycle and written back in the next.
        if (cmd.load_rd || cmd.load) begin
            hist_addr = CA_W'(load_label_reg);
        end
        if (cmd.load) begin
            hist_we = 1'b1;
        end
        if (cmd.prep_class_wr) begin
            take_we = 1'b1;
            slot_we = 1'b1;
        end
        if (cmd.prep_slot_rd) begin
            slot_addr = CA_W'(lbl_rdata);
        end
        if (cmd.prep_wr) begin
            slot_addr  = CA_W'(lbl_reg);
            slot_we    = 1'b1;
            slot_wdata = slot_rdata + CNT_W'(1);
        end
        if (cmd.emit_cnt) begin
            take_addr = CA_W'(lbl_rdata);
        end
        if (cmd.emit_fin) begin
            take_addr = CA_W'(lbl_reg);
        end
        if (cmd.emit_fin && taken) begin
            take_we    = 1'b1;
            take_wdata = take_rdata - CNT_W'(1);
        end
    end

    // Counters.
    always_comb begin
        sample_count_next = sample_count_reg;
        cursor_next       = cursor_reg;
        class_next        = class_reg;
        run_next          = run_reg;
        taken_pos_next    = taken_pos_reg;
        rem_pos_next      = rem_pos_reg;
        if (cmd.clear_start) begin
            sample_count_next = '0;
            cursor_next       = '0;
            class_next        = '0;
            taken_pos_next    = '0;
            rem_pos_next      = '0;
        end
        if (cmd.clear_step) begin
            class_next = class_reg + CC_W'(1);
        end
        if (cmd.load) begin
            sample_count_next = sample_count_reg + CNT_W'(1);
        end
        if (cmd.prep_start) begin
            class_next  = '0;
            cursor_next = '0;
            run_next    = '0;
        end
        if (cmd.prep_class_wr) begin
            class_next = class_reg + CC_W'(1);
            run_next   = run_reg + hist_rdata;
        end
        if (cmd.prep_wr) begin
            // The emission restarts from the first ordered entry.
            cursor_next = stat.sample_done ? '0 : cursor_reg + CNT_W'(1);
        end
        if (cmd.prep_class_wr && (class_reg == CC_W'(CLASS_COUNT - 1))) begin
            cursor_next = '0;
        end
        if (cmd.emit_fin) begin
            cursor_next = cursor_reg + CNT_W'(1);
            if (taken) begin
                taken_pos_next = taken_pos_reg + OUT_IDX_W'(1);
            end else begin
                rem_pos_next = rem_pos_reg + OUT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            cursor_reg       <= '0;
            class_reg        <= '0;
            run_reg          <= '0;
            taken_pos_reg    <= '0;
            rem_pos_reg      <= '0;
        end else begin
            sample_count_reg <= sample_count_next;
            cursor_reg       <= cursor_next;
            class_reg        <= class_next;
            run_reg          <= run_next;
            taken_pos_reg    <= taken_pos_next;
            rem_pos_reg      <= rem_pos_next;
        end
        take_prod_hi_reg  <= prod[PROD_W-1:16] > PROD_W'(0) ? CNT_W'(prod[PROD_W-1:16])
                                                           : CNT_W'(0);
        if (cmd.capture) begin
            load_label_reg <= in_label;
        end
        if (cmd.prep_slot_rd || cmd.emit_cnt) begin
            lbl_reg <= lbl_rdata;
        end
        if (cmd.emit_lbl) begin
            src_reg <= ord_rdata;
        end
        if (cmd.emit_fin) begin
            res_source_index  <= OUT_IDX_W'(src_reg);
            res_class_label   <= lbl_reg;
            res_to_taken      <= taken;
            res_dest_position <= taken ? taken_pos_reg : rem_pos_reg;
            res_last          <= (cursor_reg + CNT_W'(1)) == sample_count_reg;
        end
    end

    assign stat.clear_done  = (class_reg == CC_W'(CLASS_COUNT - 1));
    assign stat.class_done  = (class_reg == CC_W'(CLASS_COUNT - 1));
    assign stat.sample_done = (cursor_reg + CNT_W'(1)) >= sample_count_reg;
    assign stat.empty       = (sample_count_reg == '0);
    assign stat.full        = (sample_count_reg == CNT_W'(MAX_SAMPLES));
    assign stat.label_ok    = (CNT_W'(in_label) < CNT_W'(CLASS_COUNT)) || (CLASS_COUNT > 255);
    assign stat.emit_end    = (cursor_reg >= sample_count_reg);

endmodule

[sv/scs_ctrl.sv]
// ----------------------------------------------------------------------------
// Stratified class split controller
// Sequences clear sweeps, loads, the counting-sort pass and fetches.
// ----------------------------------------------------------------------------
module scs_ctrl import scs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic              m_ready,
    output logic              m_valid,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    typedef enum logic [14:0] {
        ST_CLR    = 15'b000000000000001,
        ST_IDLE   = 15'b000000000000010,
        ST_LOAD_R = 15'b000000000000100,
        ST_LOAD_W = 15'b000000000001000,
        ST_PC_RD  = 15'b000000000010000,
        ST_PC_MUL = 15'b000000000100000,
        ST_PC_WR  = 15'b000000001000000,
        ST_PS_RD  = 15'b000000010000000,
        ST_PS_SL  = 15'b000000100000000,
        ST_PS_WR  = 15'b000001000000000,
        ST_EM_RD  = 15'b000010000000000,
        ST_EM_LB  = 15'b000100000000000,
        ST_EM_CT  = 15'b001000000000000,
        ST_EM_FIN = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_LOADING  = 3'b001,
        PH_EMITTING = 3'b010,
        PH_DONE     = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_CLR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (cmd_t'(s_command))
                        CMD_CLEAR: begin
                            cmd.clear_start = 1'b1;
                            phase_next      = PH_LOADING;
                            state_next      = ST_CLR;
                        end
                        CMD_LOAD: begin
                            if (phase_reg == PH_LOADING && !stat.full && stat.label_ok) begin
                                state_next = ST_LOAD_R;
                            end
                        end
                        CMD_FETCH: begin
                            if (phase_reg == PH_LOADING) begin
                                if (stat.empty) begin
                                    phase_next = PH_DONE;
                                end else begin
                                    cmd.prep_start = 1'b1;
                                    phase_next     = PH_EMITTING;
                                    state_next     = ST_PC_RD;
                                end
                            end else if (phase_reg == PH_EMITTING && !stat.emit_end) begin
                                state_next = ST_EM_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD_R: begin
                cmd.load_rd = 1'b1;
                state_next  = ST_LOAD_W;
            end
            ST_LOAD_W: begin
                cmd.load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PC_RD: begin
                cmd.prep_class = 1'b1;
                state_next     = ST_PC_MUL;
            end
            ST_PC_MUL: begin
                state_next = ST_PC_WR;
            end
            ST_PC_WR: begin
                cmd.prep_class_wr = 1'b1;
                state_next = stat.class_done ? ST_PS_RD : ST_PC_RD;
            end
            ST_PS_RD: begin
                cmd.prep_rd = 1'b1;
                state_next  = ST_PS_SL;
            end
            ST_PS_SL: begin
                cmd.prep_slot_rd = 1'b1;
                state_next       = ST_PS_WR;
            end
            ST_PS_WR: begin
                cmd.prep_wr = 1'b1;
                state_next  = stat.sample_done ? ST_EM_RD : ST_PS_RD;
            end
            ST_EM_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EM_LB;
            end
            ST_EM_LB: begin
                cmd.emit_lbl = 1'b1;
                state_next   = ST_EM_CT;
            end
            ST_EM_CT: begin
                cmd.emit_cnt = 1'b1;
                state_next   = ST_EM_FIN;
            end
            ST_EM_FIN: begin
                cmd.emit_fin = 1'b1;
                if (stat.sample_done) begin
                    phase_next = PH_DONE;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            phase_reg   <= PH_LOADING;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[sv/stratified_class_split_unit.sv]
// A load runs ST_LOAD_R, ST_LOAD_W; a fetch ST_EM_RD to ST_OUT, then raises m_valid.
// The next transaction is accepted the cycle after the result is taken.
// The first fetch adds the counting-sort pass: a read, multiply and write per class,
// then a label read, slot read and index write per loaded sample (single-port RAMs).
// After reset and each clear a sweep over every class entry zeroes the class tables.
// Reset is synchronous and active low; the take rate returns to one half.
// ----------------------------------------------------------------------------
// Stratified class split unit
// Builds a class histogram from loaded labels and emits a stratified split.
// ----------------------------------------------------------------------------
module stratified_class_split_unit import scs_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int CLASS_COUNT = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RATE_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [LABEL_W-1:0]   s_label,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_IDX_W-1:0] m_source_index,
    output logic [LABEL_W-1:0]   m_class_label,
    output logic                 m_to_taken,
    output logic [OUT_IDX_W-1:0] m_dest_position,
    output logic                 m_last
);

    logic [RATE_W-1:0] rate_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            rate_reg <= cfg_data;
        end
    end

    scs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .m_ready(m_ready), .m_valid(m_valid),
        .stat(stat), .cmd(cmd)
    );

    scs_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .CLASS_COUNT(CLASS_COUNT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_label(s_label),
        .rate(rate_reg), .stat(stat),
        .res_source_index(m_source_index), .res_class_label(m_class_label),
        .res_to_taken(m_to_taken), .res_dest_position(m_dest_position),
        .res_last(m_last)
    );

endmodule

[sv/scs_checker.sv]
// ----------------------------------------------------------------------------
// Stratified class split checker
// Port-level properties of the split unit, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_last
);

    // A result stays offered until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

    // No new transaction is taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken with result pending");

    // A result is first offered only while no transaction can be taken.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready) else $error("spurious result");

    // An offered result always carries a defined end marker.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown(m_last)) else $error("undefined last flag");

    // No result is offered once reset has been applied.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result after reset");

endmodule

bind stratified_class_split_unit scs_checker u_scs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_last(m_last)
);

[tb/stratified_class_split_unit_test.sv]
// ----------------------------------------------------------------------------
// Stratified class split unit testbench
// Drives load, fetch, clear and idle commands with random gaps on both
// channels, predicts each placement with a behavioural model of the split,
// and checks every output transaction in order across several take rates.
// ----------------------------------------------------------------------------
module stratified_class_split_unit_test import scs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES = 1024;
    localparam int CLASS_COUNT = 256;
    localparam int IDLE_WAIT   = 300;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] source_index;
        logic [LABEL_W-1:0]   class_label;
        logic                 to_taken;
        logic [OUT_IDX_W-1:0] dest_position;
        logic                 last;
    } placement_t;

    typedef struct {
        cmd_t             command;
        logic [LABEL_W-1:0] label;
        bit               typed;
        bit               yields;
        placement_t       placement;
    } stim_row_t;

    typedef enum logic [1:0] {
        SPLIT_LOADING,
        SPLIT_EMITTING,
        SPLIT_DONE
    } split_phase_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RATE_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command = CMD_NONE;
    logic [LABEL_W-1:0]   s_label = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_IDX_W-1:0] m_source_index;
    logic [LABEL_W-1:0]   m_class_label;
    logic                 m_to_taken;
    logic [OUT_IDX_W-1:0] m_dest_position;
    logic                 m_last;

    stratified_class_split_unit #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .CLASS_COUNT(CLASS_COUNT)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_label(s_label),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_source_index(m_source_index), .m_class_label(m_class_label),
        .m_to_taken(m_to_taken), .m_dest_position(m_dest_position),
        .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the split state.
    logic [RATE_W-1:0]    take_rate;
    logic [LABEL_W-1:0]   stored_label [MAX_SAMPLES];
    int unsigned          histogram [CLASS_COUNT];
    int unsigned          take_left [CLASS_COUNT];
    int unsigned          sorted_src [MAX_SAMPLES];
    int unsigned          loaded, cursor, taken_pos, rest_pos;
    split_phase_t         split_phase;

    placement_t pending_placements [$];
    int unsigned mismatches = 0;
    longint      cycles = 0;
    bit          no_idle = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic clear_split();
        for (int c = 0; c < CLASS_COUNT; c++) begin
            histogram[c] = 0;
            take_left[c] = 0;
        end
        loaded = 0;
        cursor = 0;
        taken_pos = 0;
        rest_pos = 0;
        split_phase = SPLIT_LOADING;
    endtask

    // Works out the take counts and stably sorts the samples by class.
    task automatic sort_by_class();
        longint unsigned rate;
        int unsigned slot [CLASS_COUNT];
        int unsigned run;
        rate = (take_rate > RATE_ONE) ? RATE_ONE : take_rate;
        run = 0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            take_left[c] = int'((longint'(histogram[c]) * rate + 65535) >> 16);
            slot[c] = run;
            run += histogram[c];
        end
        for (int i = 0; i < loaded; i++) begin
            sorted_src[slot[stored_label[i]]] = i;
            slot[stored_label[i]]++;
        end
    endtask

    task automatic predict_placement(input cmd_t command, input logic [LABEL_W-1:0] label,
                                     output bit yields, output placement_t p);
        int unsigned src;
        yields = 1'b0;
        p = '0;
        case (command)
            CMD_CLEAR: clear_split();
            CMD_LOAD: begin
                if (split_phase == SPLIT_LOADING && loaded < MAX_SAMPLES) begin
                    stored_label[loaded] = label;
                    histogram[label]++;
                    loaded++;
                end
            end
            CMD_FETCH: begin
                if (split_phase == SPLIT_LOADING) begin
                    if (loaded == 0) begin
                        split_phase = SPLIT_DONE;
                    end else begin
                        sort_by_class();
                        split_phase = SPLIT_EMITTING;
                    end
                end
                if (split_phase == SPLIT_EMITTING && cursor < loaded) begin
                    src = sorted_src[cursor];
                    yields = 1'b1;
                    p.source_index = src[OUT_IDX_W-1:0];
                    p.class_label = stored_label[src];
                    if (take_left[p.class_label] > 0) begin
                        take_left[p.class_label]--;
                        p.to_taken = 1'b1;
                        p.dest_position = taken_pos[OUT_IDX_W-1:0];
                        taken_pos = (taken_pos + 1) & 10'h3FF;
                    end else begin
                        p.to_taken = 1'b0;
                        p.dest_position = rest_pos[OUT_IDX_W-1:0];
                        rest_pos = (rest_pos + 1) & 10'h3FF;
                    end
                    cursor++;
                    p.last = (cursor == loaded);
                    if (cursor == loaded) split_phase = SPLIT_DONE;
                end
            end
            default: ;
        endcase
    endtask

    // Presents one command and waits for its transaction; returns the
    // predicted placement so that directed rows may override it.
    task automatic send_command(input cmd_t command, input logic [LABEL_W-1:0] label,
                                output bit yields, output placement_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= command;
        s_label <= label;
        do @(posedge aclk); while (!s_ready);
        predict_placement(command, label, yields, p);
    endtask

    task automatic issue(input cmd_t command, input logic [LABEL_W-1:0] label);
        bit yields;
        placement_t p;
        send_command(command, label, yields, p);
        if (yields) pending_placements.push_back(p);
    endtask

    task automatic write_take_rate(input logic [RATE_W-1:0] rate);
        s_valid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= rate;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        take_rate = rate;
    endtask

    function automatic logic [LABEL_W-1:0] pick_label(input int span);
        if ($urandom_range(0, 9) == 0) return LABEL_W'($urandom_range(0, 255));
        return LABEL_W'($urandom_range(0, span));
    endfunction

    // One dataset: a clear, a run of loads, then fetches, with a little noise
    // and the odd sequence abandoned part way through the emission.
    task automatic run_dataset(input int n, input int span);
        int fetches;
        issue(CMD_CLEAR, LABEL_W'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) issue(CMD_NONE, LABEL_W'($urandom));
            issue(CMD_LOAD, pick_label(span));
        end
        fetches = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
        for (int i = 0; i < fetches; i++) begin
            if ($urandom_range(0, 24) == 0) issue(CMD_LOAD, pick_label(span));
            issue(CMD_FETCH, LABEL_W'($urandom));
        end
    endtask

    // Receiver with random stall stretches.
    int stall_left = 0;
    always @(posedge aclk) begin
        placement_t got, want;
        cycles++;
        if (m_valid && m_ready) begin
            got = '{m_source_index, m_class_label, m_to_taken, m_dest_position, m_last};
            if (pending_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected placement: src=%0d label=%0d taken=%0b",
                             got.source_index, got.class_label, got.to_taken,
                             " pos=%0d last=%0b", got.dest_position, got.last);
            end else begin
                want = pending_placements.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("placement mismatch: expected src=%0d label=%0d taken=%0b",
                                 want.source_index, want.class_label, want.to_taken,
                                 " pos=%0d last=%0b", want.dest_position, want.last);
                        $display("                    got      src=%0d label=%0d taken=%0b",
                                 got.source_index, got.class_label, got.to_taken,
                                 " pos=%0d last=%0b", got.dest_position, got.last);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    stim_row_t directed [$];

    function automatic stim_row_t row(input cmd_t command, input logic [LABEL_W-1:0] label,
                                      input bit typed = 0, input bit yields = 0,
                                      input placement_t p = '0);
        stim_row_t r;
        r.command = command;
        r.label = label;
        r.typed = typed;
        r.yields = yields;
        r.placement = p;
        return r;
    endfunction

    initial begin
        bit yields;
        placement_t p;
        logic [RATE_W-1:0] rates [6];
        take_rate = RATE_RESET;
        clear_split();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An empty fetch ends the dataset, and a later fetch gives nothing.
        directed.push_back(row(CMD_FETCH, 8'h00, 1));
        directed.push_back(row(CMD_FETCH, 8'hFF, 1));
        directed.push_back(row(CMD_NONE, 8'hFF, 1));
        directed.push_back(row(CMD_CLEAR, 8'h00, 1));
        directed.push_back(row(CMD_LOAD, 8'h00));
        directed.push_back(row(CMD_LOAD, 8'hFF));
        directed.push_back(row(CMD_LOAD, 8'h00));
        directed.push_back(row(CMD_FETCH, 8'h00, 1, 1, '{10'd0, 8'd0, 1'b1, 10'd0, 1'b0}));
        directed.push_back(row(CMD_FETCH, 8'h00, 1, 1, '{10'd2, 8'd0, 1'b0, 10'd0, 1'b0}));
        directed.push_back(row(CMD_FETCH, 8'h00, 1, 1, '{10'd1, 8'd255, 1'b1, 10'd1, 1'b1}));
        directed.push_back(row(CMD_FETCH, 8'h00, 1));
        // A load once fetching has begun is ignored.
        directed.push_back(row(CMD_LOAD, 8'h07, 1));
        directed.push_back(row(CMD_FETCH, 8'h00, 1));
        directed.push_back(row(CMD_CLEAR, 8'hFF, 1));
        directed.push_back(row(CMD_LOAD, 8'hAA));
        directed.push_back(row(CMD_LOAD, 8'h55));
        directed.push_back(row(CMD_LOAD, 8'hAA));
        directed.push_back(row(CMD_LOAD, 8'h55));
        directed.push_back(row(CMD_LOAD, 8'h55));
        directed.push_back(row(CMD_NONE, 8'h00));
        repeat (5) directed.push_back(row(CMD_FETCH, 8'h00));
        directed.push_back(row(CMD_CLEAR, 8'h00));

        foreach (directed[i]) begin
            send_command(directed[i].command, directed[i].label, yields, p);
            if (directed[i].typed) begin
                if (directed[i].yields) pending_placements.push_back(directed[i].placement);
            end else if (yields) begin
                pending_placements.push_back(p);
            end
        end

        rates = '{17'd0, RATE_ONE, 17'h1FFFF, 17'd1, 17'd65535, 17'd21845};
        foreach (rates[k]) begin
            write_take_rate(rates[k]);
            for (int d = 0; d < 5; d++) begin
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    run_dataset(0, 3);
                else
                    run_dataset($urandom_range(1, 12), ($urandom_range(0, 1) != 0) ? 3 : 255);
            end
            no_idle = 1'b0;
        end

        write_take_rate(17'($urandom_range(0, 65536)));
        for (int d = 0; d < 8; d++) run_dataset($urandom_range(1, 10), 7);

        s_valid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending_placements.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[stratified_class_split_unit.f]
sv/scs_pkg.sv
sv/scs_ram.sv
sv/scs_datapath.sv
sv/scs_ctrl.sv
sv/stratified_class_split_unit.sv
sv/scs_checker.sv
tb/stratified_class_split_unit_test.sv
